// ----- hdl/orfb_pkg.sv -----
// orfb_pkg: shared types and constants for the overwriting ring FIFO with burst pull.
// Used by every module of the block; depends on nothing.
package orfb_pkg;

  localparam int RingDepthDef  = 1024;
  localparam int MaxBurstDef   = 64;
  localparam int QueueDepthDef = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PULL  = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
    logic [6:0] pull_limit;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic        last;
    logic [9:0]  queue_count;
    logic [31:0] overflow_count;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic       is_pull;
    logic [7:0] data_byte;
    logic [6:0] limit;
  } cmd_t;

endpackage

// ----- hdl/overwrite_ring_fifo_burst_pull.sv -----
// Overwriting byte ring FIFO with burst pull: top level.
// Order: a write beat passes the command queue, then the back end pushes its result into
//   the result queue; a pull passes ST_READ and ST_EMIT first, then shows one byte per cycle
//   while the result queue has room. A pull holds the back end until its last byte, so
//   later commands wait; the ring memory has a single read port, read by the sequencer.
// Reset: pointers, counts and queues clear at once; ring contents are left as is.
// Depends on orfb_pkg, orfb_front, orfb_back and orfb_fifo.
module overwrite_ring_fifo_burst_pull import orfb_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDef,
  parameter int MAX_BURST  = MaxBurstDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // input side: one beat accepted on push && !full
  input  logic      push,
  input  in_item_t  in_item_i,
  output logic      full,
  // result side: oldest result shown while !empty, taken on pop && !empty
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res;

  // front: clamps the pull limit and buffers up to two commands, so input can
  // run ahead of a burst that is still draining until that buffer fills
  orfb_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: owns the ring, the pointers and both counters
  orfb_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // result queue decouples the sequencer from the consumer's pop
  orfb_fifo #(
    .T     (out_item_t),
    .DEPTH (QueueDepthDef)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

// ----- hdl/orfb_fifo.sv -----
// orfb_fifo: small register-based queue with push/full and pop/empty sides.
// Depends on orfb_pkg for the default depth.
module orfb_fifo import orfb_pkg::*; #(
  parameter type T     = cmd_t,
  parameter int  DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/orfb_front.sv -----
// orfb_front: accepts input beats, clamps the pull limit and queues commands.
// Depends on orfb_pkg and orfb_fifo.
module orfb_front import orfb_pkg::*; #(
  parameter int MAX_BURST = MaxBurstDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t cmd_in;
  logic cmd_empty;

  always_comb begin
    cmd_in.is_pull   = (item_i.opcode == OP_PULL);
    cmd_in.data_byte = item_i.data_byte;
    // zero means one byte; anything above the burst cap saturates
    if (item_i.pull_limit == '0) begin
      cmd_in.limit = 7'd1;
    end else if (item_i.pull_limit > 7'(MAX_BURST)) begin
      cmd_in.limit = 7'(MAX_BURST);
    end else begin
      cmd_in.limit = item_i.pull_limit;
    end
  end

  orfb_fifo #(
    .T     (cmd_t),
    .DEPTH (QueueDepthDef)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// ----- hdl/orfb_back.sv -----
// orfb_back: ring memory, pointers and counters; executes writes and burst pulls.
// Depends on orfb_pkg.
module orfb_back import orfb_pkg::*; #(
  parameter int RING_DEPTH = RingDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int VW = (AW + 1 > 7) ? AW + 1 : 7;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e         state_q, state_d;
  logic [AW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [AW-1:0]  held_q, held_d;
  logic [31:0]    drop_q, drop_d;
  logic [6:0]     rem_q, rem_d;
  logic [7:0]     ring_q [RING_DEPTH];
  logic [7:0]     rd_data_q;
  logic           mem_we;
  logic [AW-1:0]  wr_next, rd_next;
  logic [VW-1:0]  avail;
  kind_e          kind;
  logic [7:0]     byte_out;
  logic           last;

  assign wr_next = (wr_q == AW'(RING_DEPTH - 1)) ? '0 : wr_q + 1'b1;
  assign rd_next = (rd_q == AW'(RING_DEPTH - 1)) ? '0 : rd_q + 1'b1;

  // contiguous run: up to the write pointer, or to the ring end if data wraps
  assign avail = (wr_q > rd_q) ? VW'(wr_q - rd_q)
                               : VW'(RING_DEPTH) - VW'(rd_q);

  always_comb begin
    state_d    = state_q;
    wr_d       = wr_q;
    rd_d       = rd_q;
    held_d     = held_q;
    drop_d     = drop_q;
    rem_d      = rem_q;
    mem_we     = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    kind       = KIND_WRITE;
    byte_out   = '0;
    last       = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.is_pull) begin
            mem_we     = 1'b1;
            wr_d       = wr_next;
            res_push_o = 1'b1;
            if (wr_next == rd_q) begin
              drop_d = drop_q + 1'b1;
              rd_d   = rd_next;
            end else begin
              held_d = held_q + 1'b1;
            end
          end else if (wr_q == rd_q) begin
            res_push_o = 1'b1;
            kind       = KIND_EMPTY;
          end else begin
            rem_d   = (avail < VW'(cmd_i.limit)) ? 7'(avail) : cmd_i.limit;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        kind     = KIND_BYTE;
        byte_out = rd_data_q;
        last     = (rem_q == 7'd1);
        if (!res_full_i) begin
          res_push_o = 1'b1;
          rd_d       = rd_next;
          held_d     = held_q - 1'b1;
          rem_d      = rem_q - 1'b1;
          if (rem_q == 7'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.kind           = kind;
    res_o.out_byte       = byte_out;
    res_o.last           = last;
    res_o.queue_count    = 10'(held_d);
    res_o.overflow_count = drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wr_q    <= '0;
      rd_q    <= '0;
      held_q  <= '0;
      drop_q  <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      held_q  <= held_d;
      drop_q  <= drop_d;
      rem_q   <= rem_d;
    end
  end

  // one write port, one registered read port that follows the next read pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[wr_q] <= cmd_i.data_byte;
    end
    rd_data_q <= ring_q[rd_d];
  end

endmodule

// ----- hdl/orfb_checker.sv -----
// orfb_checker: port-level checks for the overwriting ring FIFO, plus its bind.
// Depends on orfb_pkg and the top level overwrite_ring_fifo_burst_pull.
module orfb_checker import orfb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  // nothing is shown once reset has been seen
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown during reset");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed");

  // write and empty-pull results are single beats with a zero byte
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_item_o.kind == KIND_WRITE || out_item_o.kind == KIND_EMPTY))
      |-> (out_item_o.last && out_item_o.out_byte == 8'd0))
    else $error("single-beat result malformed");

  // a burst that is not finished continues with pulled bytes, same drop count
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && out_item_o.kind == KIND_BYTE && !out_item_o.last) ##1 !empty
      |-> (out_item_o.kind == KIND_BYTE &&
           out_item_o.overflow_count == $past(out_item_o.overflow_count)))
    else $error("burst interrupted");

endmodule

bind overwrite_ring_fifo_burst_pull orfb_checker u_orfb_checker (.*);
